FILE: hdl/rvpm_pkg.sv
package rvpm_pkg;

    localparam int PIX_W     = 11;
    localparam int COORD_W   = 24;
    localparam int SUM_W     = 46;
    localparam int CNT_W     = 23;
    localparam int CFG_IDX_W = 2;

    // frame saturates at 2^22 counted points
    localparam logic [CNT_W-1:0] COUNT_LIMIT = 23'd4194304;

    // |sum| <= count * 2^23, so the quotient needs only COORD_W bits
    localparam int DIV_STEPS = COORD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [PIX_W-1:0] BOX_LEFT_RST   = 11'd0;
    localparam logic [PIX_W-1:0] BOX_TOP_RST    = 11'd0;
    localparam logic [PIX_W-1:0] BOX_RIGHT_RST  = 11'd2047;
    localparam logic [PIX_W-1:0] BOX_BOTTOM_RST = 11'd2047;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_LEFT   = 2'd0,
        CFG_BOX_TOP    = 2'd1,
        CFG_BOX_RIGHT  = 2'd2,
        CFG_BOX_BOTTOM = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEQ_ACC,
        SEQ_DIV,
        SEQ_LOAD
    } seq_state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic [PIX_W-1:0]          pixel_column;
        logic [PIX_W-1:0]          pixel_row;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic                      depth_valid;
        logic                      frame_end;
    } point_t;

    typedef struct packed {
        logic                      found;
        logic [CNT_W-1:0]          point_count;
        logic signed [COORD_W-1:0] mean_x;
        logic signed [COORD_W-1:0] mean_y;
        logic signed [COORD_W-1:0] mean_z;
    } result_t;

    typedef struct packed {
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] bottom;
    } box_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SUM_W-1:0] sum_z;
        logic [CNT_W-1:0]        count;
    } acc_t;

    typedef struct packed {
        logic take;
        logic clear;
    } acc_ctrl_t;

endpackage

FILE: hdl/rvpm_accum.sv
module rvpm_accum #(
    parameter int MAX_COLUMNS = 2048,
    parameter int MAX_ROWS    = 2048
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rvpm_pkg::acc_ctrl_t ctrl,
    input  rvpm_pkg::point_t    point,
    input  rvpm_pkg::box_t      box,
    output rvpm_pkg::acc_t      acc
);

    localparam int EXT_W = rvpm_pkg::SUM_W - rvpm_pkg::COORD_W;

    rvpm_pkg::acc_t acc_reg;
    rvpm_pkg::acc_t acc_next;
    logic           hit;

    always_comb
    begin
        hit = point.depth_valid
            && (32'(point.pixel_column) < 32'(MAX_COLUMNS))
            && (32'(point.pixel_row) < 32'(MAX_ROWS))
            && (point.pixel_column >= box.left) && (point.pixel_column <= box.right)
            && (point.pixel_row >= box.top) && (point.pixel_row <= box.bottom)
            && (acc_reg.count < rvpm_pkg::COUNT_LIMIT);

        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.take && hit)
        begin
            acc_next.sum_x = acc_reg.sum_x
                + {{EXT_W{point.coord_x[rvpm_pkg::COORD_W-1]}}, point.coord_x};
            acc_next.sum_y = acc_reg.sum_y
                + {{EXT_W{point.coord_y[rvpm_pkg::COORD_W-1]}}, point.coord_y};
            acc_next.sum_z = acc_reg.sum_z
                + {{EXT_W{point.coord_z[rvpm_pkg::COORD_W-1]}}, point.coord_z};
            acc_next.count = acc_reg.count + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

`ifndef NO_ASSERTIONS
    a_count_saturates : assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg.count <= rvpm_pkg::COUNT_LIMIT)
        else $error("point count above frame limit");

    a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (acc_reg.count == '0) && (acc_reg.sum_x == '0))
        else $error("accumulators not cleared");
`endif

endmodule

FILE: hdl/rvpm_div.sv
module rvpm_div (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [rvpm_pkg::SUM_W-1:0]       dividend,
    input  logic [rvpm_pkg::CNT_W-1:0]              divisor,
    output logic                                    done,
    output logic signed [rvpm_pkg::COORD_W-1:0]     quotient
);

    localparam int SW = rvpm_pkg::SUM_W;
    localparam int CW = rvpm_pkg::CNT_W;
    localparam int QW = rvpm_pkg::COORD_W;

    logic                                run_reg;
    logic                                run_next;
    logic                                done_reg;
    logic                                done_next;
    logic [rvpm_pkg::STEP_W-1:0]         step_reg;
    logic [rvpm_pkg::STEP_W-1:0]         step_next;
    logic                                neg_reg;
    logic                                neg_next;
    logic [CW-1:0]                       rem_reg;
    logic [CW-1:0]                       rem_next;
    logic [QW-1:0]                       quo_reg;
    logic [QW-1:0]                       quo_next;
    logic [SW-1:0]                       mag;
    logic [CW:0]                         trial;
    logic                                ge;

    always_comb
    begin
        mag   = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
        trial = {rem_reg, quo_reg[QW-1]};
        ge    = trial >= {1'b0, divisor};

        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            // high part is below the divisor, so only the low QW bits make quotient
            run_next  = 1'b1;
            step_next = '0;
            neg_next  = dividend[SW-1];
            rem_next  = CW'(mag[SW-1:QW]);
            quo_next  = mag[QW-1:0];
        end
        else if (run_reg)
        begin
            rem_next  = ge ? CW'(trial - {1'b0, divisor}) : CW'(trial);
            quo_next  = {quo_reg[QW-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == rvpm_pkg::STEP_W'(rvpm_pkg::DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // truncation toward zero: divide magnitudes, then restore the sign
    assign quotient = neg_reg ? QW'(-quo_reg) : quo_reg;
    assign done     = done_reg;

`ifndef NO_ASSERTIONS
    a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("divider restarted while running");

    a_done_after_run : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg && $past(run_reg))
        else $error("divider done without a run");
`endif

endmodule

FILE: hdl/roi_valid_point_mean.sv
// Non-final point: accepted every cycle, one add per coordinate, no result.
// Frame-end point: the result appears after three runs of the shared divider
// plus load; point input stalls until then, longer if the result register is
// still held by a stalled consumer.
// Reset (rst_n, async, active low) clears sums, count, sequencer, result valid,
// and sets the box to the whole 2048 x 2048 cloud.
module roi_valid_point_mean #(
    parameter int MAX_COLUMNS = 2048,
    parameter int MAX_ROWS    = 2048
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // point items
    input  logic                               pt_valid,
    output logic                               pt_stall,
    input  rvpm_pkg::point_t                   pt_data,
    // result items
    output logic                               res_valid,
    input  logic                               res_stall,
    output rvpm_pkg::result_t                  res_data,
    // box register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rvpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rvpm_pkg::PIX_W-1:0]         cfg_data
);

    localparam int QW = rvpm_pkg::COORD_W;

    rvpm_pkg::seq_state_t               seq_reg;
    rvpm_pkg::seq_state_t               seq_next;
    rvpm_pkg::axis_t                    axis_reg;
    rvpm_pkg::axis_t                    axis_next;
    logic                               start_reg;
    logic                               start_next;
    rvpm_pkg::result_t                  pend_reg;
    rvpm_pkg::result_t                  pend_next;
    logic                               res_valid_reg;
    logic                               res_valid_next;
    rvpm_pkg::result_t                  res_data_reg;
    rvpm_pkg::result_t                  res_data_next;
    rvpm_pkg::box_t                     box_reg;

    rvpm_pkg::acc_ctrl_t                acc_ctrl;
    rvpm_pkg::acc_t                     acc;
    logic                               pt_take;
    logic signed [rvpm_pkg::SUM_W-1:0]  dividend;
    logic                               div_done;
    logic signed [QW-1:0]               div_q;
    logic signed [QW-1:0]               mean;

    // ---------------------------------------------------------------
    // Box registers: writes are always taken
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.left   <= rvpm_pkg::BOX_LEFT_RST;
            box_reg.top    <= rvpm_pkg::BOX_TOP_RST;
            box_reg.right  <= rvpm_pkg::BOX_RIGHT_RST;
            box_reg.bottom <= rvpm_pkg::BOX_BOTTOM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (rvpm_pkg::cfg_reg_t'(cfg_index))
                rvpm_pkg::CFG_BOX_LEFT:   box_reg.left   <= cfg_data;
                rvpm_pkg::CFG_BOX_TOP:    box_reg.top    <= cfg_data;
                rvpm_pkg::CFG_BOX_RIGHT:  box_reg.right  <= cfg_data;
                rvpm_pkg::CFG_BOX_BOTTOM: box_reg.bottom <= cfg_data;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Accumulator: adds a point the cycle it is accepted. It holds its
    // sums through the divide and is cleared once the last mean is in.
    // ---------------------------------------------------------------
    assign pt_stall = (seq_reg != rvpm_pkg::SEQ_ACC);
    assign pt_take  = pt_valid && !pt_stall;

    rvpm_accum #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (acc_ctrl),
        .point (pt_data),
        .box   (box_reg),
        .acc   (acc)
    );

    // ---------------------------------------------------------------
    // One serial divider, run once per axis (x, y, z)
    // ---------------------------------------------------------------
    always_comb
    begin
        unique case (axis_reg)
            rvpm_pkg::AXIS_X: dividend = acc.sum_x;
            rvpm_pkg::AXIS_Y: dividend = acc.sum_y;
            rvpm_pkg::AXIS_Z: dividend = acc.sum_z;
            default:          dividend = acc.sum_x;
        endcase
    end

    rvpm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (dividend),
        .divisor  (acc.count),
        .done     (div_done),
        .quotient (div_q)
    );

    // empty frame: means are zero, whatever the divider returns
    assign mean = (acc.count == '0) ? '0 : div_q;

    // ---------------------------------------------------------------
    // Sequencer
    // ACC : take points; frame end starts the x divide
    // DIV : step through the axes, collecting means into pend_reg
    // LOAD: move pend_reg into the output register once it is free
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= rvpm_pkg::SEQ_ACC;
            axis_reg      <= rvpm_pkg::AXIS_X;
            start_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            axis_reg      <= axis_next;
            start_reg     <= start_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        res_data_reg <= res_data_next;
    end

    always_comb
    begin
        seq_next       = seq_reg;
        axis_next      = axis_reg;
        start_next     = 1'b0;
        pend_next      = pend_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_data_next  = res_data_reg;
        acc_ctrl.take  = pt_take;
        acc_ctrl.clear = 1'b0;

        unique case (seq_reg)
            rvpm_pkg::SEQ_ACC:
            begin
                if (pt_take && pt_data.frame_end)
                begin
                    seq_next   = rvpm_pkg::SEQ_DIV;
                    axis_next  = rvpm_pkg::AXIS_X;
                    start_next = 1'b1;
                end
            end
            rvpm_pkg::SEQ_DIV:
            begin
                if (div_done)
                begin
                    unique case (axis_reg)
                        rvpm_pkg::AXIS_X:
                        begin
                            pend_next.mean_x = mean;
                            axis_next        = rvpm_pkg::AXIS_Y;
                            start_next       = 1'b1;
                        end
                        rvpm_pkg::AXIS_Y:
                        begin
                            pend_next.mean_y = mean;
                            axis_next        = rvpm_pkg::AXIS_Z;
                            start_next       = 1'b1;
                        end
                        default:
                        begin
                            pend_next.mean_z      = mean;
                            pend_next.found       = (acc.count != '0);
                            pend_next.point_count = acc.count;
                            acc_ctrl.clear        = 1'b1;
                            seq_next              = rvpm_pkg::SEQ_LOAD;
                        end
                    endcase
                end
            end
            rvpm_pkg::SEQ_LOAD:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = pend_reg;
                    seq_next       = rvpm_pkg::SEQ_ACC;
                end
            end
            default:
            begin
                seq_next = rvpm_pkg::SEQ_ACC;
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

`ifndef NO_ASSERTIONS
    a_result_from_load : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(seq_reg) == rvpm_pkg::SEQ_LOAD)
        else $error("result raised outside load");

    a_found_matches_count : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_data_reg.found == (res_data_reg.point_count != '0)))
        else $error("found flag disagrees with count");
`endif

endmodule
